// ===== hw/rtl/slcan_pkg.sv =====
// Shared types, constants and helper functions for the serial-line CAN frame parser.
`default_nettype none

package slcan_pkg;

	// Frame kind selected by the first character of a line.
	typedef enum logic [2:0] {
		KindNone   = 3'd0,
		KindStd    = 3'd1,
		KindExt    = 3'd2,
		KindStdRtr = 3'd3,
		KindExtRtr = 3'd4,
		KindErr    = 3'd5
	} kind_t;

	// Error kind reported for error frames.
	typedef enum logic [2:0] {
		ErrNone    = 3'd0,
		ErrBit     = 3'd1,
		ErrStuff   = 3'd2,
		ErrForm    = 3'd3,
		ErrAck     = 3'd4,
		ErrCrc     = 3'd5,
		ErrBusOff  = 3'd6,
		ErrPassive = 3'd7
	} err_kind_t;

	localparam logic [7:0] ChStd    = 8'h74; // t
	localparam logic [7:0] ChExt    = 8'h54; // T
	localparam logic [7:0] ChStdRtr = 8'h72; // r
	localparam logic [7:0] ChExtRtr = 8'h52; // R
	localparam logic [7:0] ChErr    = 8'h46; // F
	localparam logic [7:0] ChCr     = 8'h0D;

	localparam logic [3:0]  MaxDataBytes = 4'd8;
	localparam logic [3:0]  StdIdDigits  = 4'd3;
	localparam logic [3:0]  ExtIdDigits  = 4'd8;
	localparam logic [31:0] StdIdMax     = 32'h0000_07FF;
	localparam logic [31:0] ExtIdMax     = 32'h1FFF_FFFF;
	localparam logic [6:0]  ErrLineMin   = 7'd9;
	localparam logic [25:0] TsScale      = 26'd1000;
	localparam logic [5:0]  PosMax       = 6'd63;

	// Nibble value of a hex digit in bits 3:0; bit 4 set when the byte is no hex digit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slcan_char_if.sv =====
// Character channel: one ASCII byte of a line with its end-of-line mark.
`default_nettype none

interface slcan_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_line;

	modport source (output valid, output character, output end_of_line, input ready);
	modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slcan_frame_if.sv =====
// Frame channel: one parsed frame result per line.
`default_nettype none

interface slcan_frame_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic        is_error_frame;
	logic        is_extended;
	logic        is_remote;
	logic [31:0] ident;
	logic [3:0]  data_length;
	logic [63:0] payload;
	logic        timestamp_present;
	logic [25:0] stamp_usec;
	logic [2:0]  error_kind;

	modport source (
		output valid, output frame_ok, output is_error_frame, output is_extended,
		output is_remote, output ident, output data_length, output payload,
		output timestamp_present, output stamp_usec, output error_kind,
		input ready
	);
	modport sink (
		input valid, input frame_ok, input is_error_frame, input is_extended,
		input is_remote, input ident, input data_length, input payload,
		input timestamp_present, input stamp_usec, input error_kind,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/slcan_line_to_can_frame_unit.sv =====
// Top level: parses serial-line CAN text lines, one character per cycle, into frames.
//
// Channel  Dir  Payload                                    Moves per request
// chars    in   character[7:0], end_of_line                one byte of a line
// frames   out  frame_ok .. error_kind (ten fields)        one parsed frame per line
//
// One character is taken per clock while no line end waits in the input register; the line
// state updates from the input register. A frame result is loaded into the output register at
// the same edge at which its last character leaves the input register, and is offered from there.
// Reset clears the line state and empties both registers.
// Only a line-ending character waits in the input register while a result is not taken;
// other characters keep flowing while the output is stalled.
`default_nettype none

module slcan_line_to_can_frame_unit #(
	parameter logic [3:0] MaxDataBytes = slcan_pkg::MaxDataBytes
) (
	input wire logic      clk,
	input wire logic      arst_n,
	slcan_char_if.sink    chars,
	slcan_frame_if.source frames
);

	typedef struct packed {
		logic        frame_ok;
		logic        is_error_frame;
		logic        is_extended;
		logic        is_remote;
		logic [31:0] ident;
		logic [3:0]  data_length;
		logic [63:0] payload;
		logic        timestamp_present;
		logic [25:0] stamp_usec;
		logic [2:0]  error_kind;
	} result_t;

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;

	// Line state
	logic [5:0]           pos_q;
	slcan_pkg::kind_t     kind_q;
	logic [31:0]          ident_q;
	logic [3:0]           len_q;
	logic [63:0]          pay_q;
	logic                 fault_q;
	logic [31:0]          win_q;

	// Output register
	logic    out_valid_q;
	result_t res_q;

	slcan_pkg::kind_t kind_d;
	logic [31:0]      ident_d;
	logic [3:0]       len_d;
	logic [63:0]      pay_d;
	logic             fault_d;
	result_t          res_d;

	logic       advance;
	logic [4:0] v;
	logic [6:0] pos_x;
	logic [6:0] nid;
	logic       remote;
	logic [6:0] off;
	logic [3:0] nib_idx;
	logic [6:0] line_len;
	logic       ok;
	logic       is_err;
	logic       is_ext;
	logic       is_rtr;
	logic [31:0] ts_chars;
	logic [4:0]  ts_nib [4];
	logic        ts_ok;
	logic [15:0] ts_ms;
	logic [2:0]  ekind;

	assign advance      = valid_s1 && (!eol_s1 || !out_valid_q || frames.ready);
	assign chars.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
			eol_s1   <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
			char_s1  <= chars.character;
			eol_s1   <= chars.end_of_line;
		end
	end

	// Per-character update of the line state.
	always_comb begin
		kind_d  = kind_q;
		ident_d = ident_q;
		len_d   = len_q;
		pay_d   = pay_q;
		fault_d = fault_q;
		v       = slcan_pkg::hex_nibble(char_s1);
		pos_x   = {1'b0, pos_q};
		nid     = (kind_q == slcan_pkg::KindStd || kind_q == slcan_pkg::KindStdRtr)
			? {3'd0, slcan_pkg::StdIdDigits} : {3'd0, slcan_pkg::ExtIdDigits};
		remote  = (kind_q == slcan_pkg::KindStdRtr || kind_q == slcan_pkg::KindExtRtr);
		off     = pos_x - (nid + 7'd2);
		nib_idx = {off[3:1], ~off[0]};
		if (pos_q == 6'd0) begin
			case (char_s1)
				slcan_pkg::ChStd:    kind_d = slcan_pkg::KindStd;
				slcan_pkg::ChExt:    kind_d = slcan_pkg::KindExt;
				slcan_pkg::ChStdRtr: kind_d = slcan_pkg::KindStdRtr;
				slcan_pkg::ChExtRtr: kind_d = slcan_pkg::KindExtRtr;
				slcan_pkg::ChErr:    kind_d = slcan_pkg::KindErr;
				default: begin
					kind_d  = slcan_pkg::KindNone;
					fault_d = 1'b1;
				end
			endcase
		end else if (kind_q != slcan_pkg::KindNone) begin
			if (pos_x <= nid) begin
				if (v[4]) begin
					fault_d = 1'b1;
				end else begin
					ident_d = {ident_q[27:0], v[3:0]};
				end
			end else if (kind_q != slcan_pkg::KindErr) begin
				if (pos_x == nid + 7'd1) begin
					if (slcan_pkg::is_digit(char_s1)) begin
						len_d = char_s1[3:0];
						if (char_s1[3:0] > MaxDataBytes) begin
							fault_d = 1'b1;
						end
					end else begin
						fault_d = 1'b1;
					end
				end else if (!remote && len_q <= MaxDataBytes &&
					pos_x >= nid + 7'd2 && pos_x < nid + 7'd2 + {2'd0, len_q, 1'b0}) begin
					if (v[4]) begin
						fault_d = 1'b1;
					end else begin
						for (int i = 0; i < 16; i++) begin
							if (nib_idx == 4'(i)) begin
								pay_d[4*i +: 4] = pay_q[4*i +: 4] | v[3:0];
							end
						end
					end
				end
			end
		end
	end

	// Line-end evaluation on the updated state.
	always_comb begin
		line_len = pos_x + 7'd1;
		is_err   = (kind_d == slcan_pkg::KindErr);
		is_ext   = (kind_d == slcan_pkg::KindExt || kind_d == slcan_pkg::KindExtRtr);
		is_rtr   = (kind_d == slcan_pkg::KindStdRtr || kind_d == slcan_pkg::KindExtRtr);
		ok       = !fault_d && kind_d != slcan_pkg::KindNone;
		if (is_err) begin
			if (line_len < slcan_pkg::ErrLineMin) begin
				ok = 1'b0;
			end
		end else begin
			if (is_ext) begin
				if (line_len < {3'd0, slcan_pkg::ExtIdDigits} + 7'd2) ok = 1'b0;
				if (!is_rtr && line_len < {3'd0, slcan_pkg::ExtIdDigits} + 7'd2 +
					{2'd0, len_d, 1'b0}) ok = 1'b0;
				if (ident_d > slcan_pkg::ExtIdMax) ok = 1'b0;
			end else begin
				if (line_len < {3'd0, slcan_pkg::StdIdDigits} + 7'd2) ok = 1'b0;
				if (!is_rtr && line_len < {3'd0, slcan_pkg::StdIdDigits} + 7'd2 +
					{2'd0, len_d, 1'b0}) ok = 1'b0;
				if (ident_d > slcan_pkg::StdIdMax) ok = 1'b0;
			end
		end

		// Lowest set code bit among bits 0..6 names the error kind.
		ekind = slcan_pkg::ErrNone;
		for (int i = 6; i >= 0; i--) begin
			if (ident_d[i]) begin
				ekind = 3'(i + 1);
			end
		end

		// Timestamp: last four characters, skipping one final carriage return.
		// Window bytes that never held a character are zero and so never hex.
		ts_chars = (char_s1 == slcan_pkg::ChCr) ? win_q : {win_q[23:0], char_s1};
		for (int i = 0; i < 4; i++) begin
			ts_nib[i] = slcan_pkg::hex_nibble(ts_chars[8*(3-i) +: 8]);
		end
		ts_ok = ok && !is_err && !ts_nib[0][4] && !ts_nib[1][4] && !ts_nib[2][4]
			&& !ts_nib[3][4];
		ts_ms = ts_ok ? {ts_nib[0][3:0], ts_nib[1][3:0], ts_nib[2][3:0], ts_nib[3][3:0]}
			: 16'd0;

		res_d.frame_ok          = ok;
		res_d.is_error_frame    = ok && is_err;
		res_d.is_extended       = ok && is_ext;
		res_d.is_remote         = ok && is_rtr;
		res_d.ident             = ok ? ident_d : 32'd0;
		res_d.data_length       = (ok && !is_err) ? len_d : 4'd0;
		res_d.payload           = (ok && !is_err && !is_rtr) ? pay_d : 64'd0;
		res_d.timestamp_present = ts_ok;
		res_d.stamp_usec        = {10'd0, ts_ms} * slcan_pkg::TsScale;
		res_d.error_kind        = (ok && is_err) ? ekind : 3'(slcan_pkg::ErrNone);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			kind_q  <= slcan_pkg::KindNone;
			ident_q <= '0;
			len_q   <= '0;
			pay_q   <= '0;
			fault_q <= 1'b0;
			win_q   <= '0;
		end else if (advance) begin
			if (eol_s1) begin
				pos_q   <= '0;
				kind_q  <= slcan_pkg::KindNone;
				ident_q <= '0;
				len_q   <= '0;
				pay_q   <= '0;
				fault_q <= 1'b0;
				win_q   <= '0;
			end else begin
				pos_q   <= (pos_q == slcan_pkg::PosMax) ? slcan_pkg::PosMax : pos_q + 6'd1;
				kind_q  <= kind_d;
				ident_q <= ident_d;
				len_q   <= len_d;
				pay_q   <= pay_d;
				fault_q <= fault_d;
				win_q   <= {win_q[23:0], char_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eol_s1) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eol_s1) begin
			res_q <= res_d;
		end
	end

	assign frames.valid             = out_valid_q;
	assign frames.frame_ok          = res_q.frame_ok;
	assign frames.is_error_frame    = res_q.is_error_frame;
	assign frames.is_extended       = res_q.is_extended;
	assign frames.is_remote         = res_q.is_remote;
	assign frames.ident             = res_q.ident;
	assign frames.data_length       = res_q.data_length;
	assign frames.payload           = res_q.payload;
	assign frames.timestamp_present = res_q.timestamp_present;
	assign frames.stamp_usec        = res_q.stamp_usec;
	assign frames.error_kind        = res_q.error_kind;

	// A rejected line carries no frame content.
	a_bad_line_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.frame_ok |-> res_q.ident == 32'd0 && res_q.payload == 64'd0
		&& !res_q.timestamp_present && res_q.error_kind == slcan_pkg::ErrNone)
		else $error("rejected line carries frame fields");

	a_ts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.timestamp_present |-> res_q.stamp_usec == 26'd0)
		else $error("timestamp value without timestamp");

	a_err_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.is_error_frame |-> res_q.data_length == 4'd0
		&& !res_q.timestamp_present && !res_q.is_remote)
		else $error("error frame with data fields");

	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eol_s1 |=> pos_q == 6'd0 && kind_q == slcan_pkg::KindNone && !fault_q)
		else $error("line state not cleared after line end");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && eol_s1 && out_valid_q && !frames.ready)
		else $error("input stalled without a pending line end");

endmodule

`default_nettype wire
